[design/fcfs_pkg.sv]
`default_nettype none

package fcfs_pkg;

    // default store depth
    localparam int MAX_PROCS_DEF = 16;

    // field widths
    localparam int TIME_W  = 16;
    localparam int CLK_W   = 21;
    localparam int ID_W    = 5;

    // completion saturates here
    localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};

    // one input transaction
    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_time;
        logic              last_item;
    } t_in;

    // one result transaction
    typedef struct packed {
        logic [ID_W-1:0]   proc_id;
        logic [TIME_W-1:0] arrival_out;
        logic [TIME_W-1:0] burst_out;
        logic [CLK_W-1:0]  completion;
        logic [CLK_W-1:0]  turnaround;
        logic [CLK_W-1:0]  waiting;
        logic              overflow;
        logic              run_end;
    } t_out;

    // stored record
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } t_entry;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC1,
        S_CALC2,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // input transaction accepted
        logic scan_clr;  // restart min search
        logic scan;      // min search step
        logic calc1;     // completion stage
        logic calc2;     // turnaround/waiting stage, load output reg
        logic run_clr;   // run finished, empty the set
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic run_end;
    } t_dp_sts;

endpackage

`default_nettype wire

[design/fcfs_ctrl.sv]
`default_nettype none

module fcfs_ctrl
    import fcfs_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    input  wire      i_in_last,
    output logic     o_in_ready,
    input  wire      i_out_ready,
    output logic     o_out_valid,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_CALC1;
                end
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.run_end) begin
                        o_cmd.run_clr = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/fcfs_dp.sv]
`default_nettype none

module fcfs_dp
    import fcfs_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_in      i_in_data,
    input  t_dp_cmd  i_cmd,
    output t_dp_sts  o_sts,
    output t_out     o_out_data
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    // record store
    t_entry r_mem [MAX_PROCS];
    t_entry r_rd_data;

    // set bookkeeping
    logic [CW-1:0]        r_count;
    logic                 r_drop;
    logic [CLK_W-1:0]     r_finish;
    logic [MAX_PROCS-1:0] r_used;
    logic [CW-1:0]        r_emit;

    // min search
    logic [CW-1:0]        r_scan;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_have_best;
    logic [TIME_W-1:0]    r_best_arr;
    logic [TIME_W-1:0]    r_best_bur;
    logic [IW-1:0]        r_best_idx;

    // arithmetic stages
    logic [CLK_W-1:0]     r_done;
    logic [CLK_W-1:0]     r_ab;
    t_out                 r_out;

    logic                 room;
    logic                 issue;
    logic                 take;
    logic [CLK_W-1:0]     arr_ext;
    logic [CLK_W-1:0]     start;
    logic [CLK_W:0]       sum;
    logic [CLK_W-1:0]     n_done;
    logic [CLK_W-1:0]     n_turn;
    logic [CLK_W-1:0]     n_wait;
    logic [31:0]          id_full;
    logic [CW:0]          emit_inc;

    assign room  = (r_count < CW'(MAX_PROCS));
    assign issue = i_cmd.scan && (r_scan < r_count);
    assign take  = i_cmd.scan && r_rd_vld && !r_used[r_rd_idx]
                   && (!r_have_best || (r_rd_data.arrival < r_best_arr));

    // completion: max(previous, arrival) + burst, saturated
    always_comb begin
        arr_ext = CLK_W'(r_best_arr);
        start   = (r_finish > arr_ext) ? r_finish : arr_ext;
        sum     = {1'b0, start} + (CLK_W + 1)'(r_best_bur);
        n_done  = (sum > {1'b0, CLOCK_MAX}) ? CLOCK_MAX : sum[CLK_W-1:0];
    end

    // turnaround and waiting from the registered completion
    always_comb begin
        n_turn   = r_done - arr_ext;
        n_wait   = (r_done >= r_ab) ? (r_done - r_ab) : '0;
        id_full  = 32'(r_best_idx) + 32'd1;
        emit_inc = {1'b0, r_emit} + (CW + 1)'(1);
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            r_mem[r_count[IW-1:0]] <= {i_in_data.arrival_time, i_in_data.burst_time};
        end
        if (issue) begin
            r_rd_data <= r_mem[r_scan[IW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_finish    <= '0;
            r_used      <= '0;
            r_emit      <= '0;
            r_scan      <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.scan_clr) begin
                r_scan      <= '0;
                r_rd_vld    <= 1'b0;
                r_have_best <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_scan <= r_scan + CW'(1);
                end
                if (take) begin
                    r_have_best <= 1'b1;
                end
            end
            if (i_cmd.calc1) begin
                r_finish <= n_done;
            end
            if (i_cmd.calc2) begin
                r_used[r_best_idx] <= 1'b1;
                r_emit             <= emit_inc[CW-1:0];
            end
            if (i_cmd.run_clr) begin
                r_count  <= '0;
                r_drop   <= 1'b0;
                r_finish <= '0;
                r_used   <= '0;
                r_emit   <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx <= r_scan[IW-1:0];
        end
        if (take) begin
            r_best_arr <= r_rd_data.arrival;
            r_best_bur <= r_rd_data.burst;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.calc1) begin
            r_done <= n_done;
            r_ab   <= CLK_W'(r_best_arr) + CLK_W'(r_best_bur);
        end
        if (i_cmd.calc2) begin
            r_out.proc_id     <= id_full[ID_W-1:0];
            r_out.arrival_out <= r_best_arr;
            r_out.burst_out   <= r_best_bur;
            r_out.completion  <= r_done;
            r_out.turnaround  <= n_turn;
            r_out.waiting     <= n_wait;
            r_out.overflow    <= r_drop;
            r_out.run_end     <= (emit_inc == {1'b0, r_count});
        end
    end

    assign o_sts.scan_done = (r_scan == r_count) && !r_rd_vld;
    assign o_sts.run_end   = r_out.run_end;
    assign o_out_data      = r_out;

endmodule

`default_nettype wire

[design/fcfs_schedule_times_top.sv]
// First-come-first-served schedule calculator.
// Input channel (i_in_valid / o_in_ready / i_in_data) loads one process record
// per transaction; records are numbered 1, 2, 3 in load order. Records beyond
// MAX_PROCS are dropped and flag overflow on every result of the set.
// The transaction with last_item set starts the run: results come out on the
// output channel (o_out_valid / i_out_ready / o_out_data) in stable arrival
// order, one per stored record, run_end set on the final one.
// Loading takes one cycle per transaction. For each result, with n being the
// records stored, a min search reads the record store one entry per cycle,
// two arithmetic stages follow, then the output register is shown.
// Results are computed one at a time: the next search starts only once
// the previous result is taken.
// The input channel is held off from the last load until the final result
// is taken. A stall on i_out_ready simply holds the result and the search.
// Synchronous reset empties the set (count, overflow, clock); the record
// store itself is not cleared and needs no clearing pass.
`default_nettype none

module fcfs_schedule_times_top
    import fcfs_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in_data,
    output logic  o_out_valid,
    input  wire   i_out_ready,
    output t_out  o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    fcfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_item),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // store, search and arithmetic
    fcfs_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

[design/fcfs_chk.sv]
`default_nettype none

module fcfs_chk
    import fcfs_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  i_in_valid,
    input wire  o_in_ready,
    input t_in  i_in_data,
    input wire  o_out_valid,
    input wire  i_out_ready,
    input t_out o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // last load closes the input side
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last_item |=> !o_in_ready)
        else $error("input still ready after last item");

    // final result ends the run
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.run_end |=> !o_out_valid && o_in_ready)
        else $error("run did not end after final result");

    // completion never precedes arrival
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.completion >= CLK_W'(o_out_data.arrival_out))
        else $error("completion before arrival");

endmodule

bind fcfs_schedule_times_top fcfs_chk u_chk (.*);

`default_nettype wire
